/* sv/uoi_pkg.sv */
`default_nettype none

package uoi_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH = 24;
    localparam int IDX_W = 5;
    localparam int ADDR_W = 3;

    // field widths
    localparam int CMD_W = 2;
    localparam int VEL_W = 24;
    localparam int POS_W = 32;
    localparam int HEAD_W = 19;
    localparam int HALF_W = 18;
    localparam int STEP_W = 16;
    localparam int WRAP_W = 25;
    localparam int ANG_W = 34;
    localparam int MUL_A_W = 32;
    localparam int PROD_W = MUL_A_W + VEL_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_VEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_POSE = 2'd2;

    // register addresses
    localparam logic [ADDR_W-1:0] ADDR_TIME_STEP = 3'd0;
    localparam logic [STEP_W-1:0] TIME_STEP_RST = 16'd655;

    // multiplier operand selects
    localparam logic [1:0] MS_HEAD = 2'd0;
    localparam logic [1:0] MS_DV = 2'd1;
    localparam logic [1:0] MS_X = 2'd2;
    localparam logic [1:0] MS_Y = 2'd3;

    // angle constants
    localparam longint PI_Q30 = 64'd3373259426;
    localparam longint HALF_PI_Q30 = PI_Q30 / 2;
    localparam longint GAIN_Q30 = 64'd652032874;
    localparam longint PI_Q = (PI_Q30 + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
    localparam longint TWO_PI_Q = 2 * PI_Q;
    localparam int WRAP_TOP = 5;

    // controller to datapath commands
    typedef struct packed {
        logic ld_vel;
        logic ld_pose;
        logic mul_en;
        logic [1:0] mul_sel;
        logic add_h;
        logic wrap_pre;
        logic wrap_step;
        logic wrap_fix;
        logic cordic_init;
        logic cordic_half;
        logic cordic_step;
        logic cordic_save;
        logic dv_save;
        logic add_x;
        logic add_y;
        logic out_load;
        logic [IDX_W-1:0] idx;
    } uoi_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_full;
    } uoi_sts_t;

    // arctangent table, Q30
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0: r = 34'sd843314857;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043837;
            5'd3: r = 34'sd133525159;
            5'd4: r = 34'sd67021687;
            5'd5: r = 34'sd33543516;
            5'd6: r = 34'sd16775851;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194283;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/uoi_ctrl.sv */
`default_nettype none

module uoi_ctrl #(
    parameter int CORDIC_STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic [uoi_pkg::CMD_W-1:0] command,
    output logic in_stall,
    input  uoi_pkg::uoi_sts_t sts,
    output uoi_pkg::uoi_cmd_t cmd
);
    import uoi_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MUL_H = 5'd1;
    localparam logic [4:0] S_ADD_H = 5'd2;
    localparam logic [4:0] S_WRAP_PRE = 5'd3;
    localparam logic [4:0] S_WRAP = 5'd4;
    localparam logic [4:0] S_WRAP_FIX = 5'd5;
    localparam logic [4:0] S_C1_INIT = 5'd6;
    localparam logic [4:0] S_C1_RUN = 5'd7;
    localparam logic [4:0] S_C1_SAVE = 5'd8;
    localparam logic [4:0] S_MUL_DV = 5'd9;
    localparam logic [4:0] S_DV_SAVE = 5'd10;
    localparam logic [4:0] S_MUL_X = 5'd11;
    localparam logic [4:0] S_ADD_X = 5'd12;
    localparam logic [4:0] S_MUL_Y = 5'd13;
    localparam logic [4:0] S_ADD_Y = 5'd14;
    localparam logic [4:0] S_C2_INIT = 5'd15;
    localparam logic [4:0] S_C2_RUN = 5'd16;
    localparam logic [4:0] S_C2_SAVE = 5'd17;
    localparam logic [4:0] S_EMIT = 5'd18;

    logic [4:0] state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic tick_reg, tick_next;

    assign in_stall = (state_reg != S_IDLE);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            tick_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            tick_reg <= tick_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        tick_next = tick_reg;
        cmd = '0;
        cmd.idx = IDX_W'(cnt_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_TICK:
                        begin
                            tick_next = 1'b1;
                            state_next = S_MUL_H;
                        end
                        CMD_SET_VEL: cmd.ld_vel = 1'b1;
                        CMD_SET_POSE:
                        begin
                            cmd.ld_pose = 1'b1;
                            tick_next = 1'b0;
                            state_next = S_WRAP_PRE;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL_H:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MS_HEAD;
                state_next = S_ADD_H;
            end
            S_ADD_H:
            begin
                cmd.add_h = 1'b1;
                state_next = S_WRAP_PRE;
            end
            S_WRAP_PRE:
            begin
                cmd.wrap_pre = 1'b1;
                cnt_next = CNT_W'(WRAP_TOP);
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_WRAP_FIX;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_WRAP_FIX:
            begin
                cmd.wrap_fix = 1'b1;
                state_next = tick_reg ? S_C1_INIT : S_IDLE;
            end
            S_C1_INIT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next = '0;
                state_next = S_C1_RUN;
            end
            S_C1_RUN:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_C1_SAVE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_C1_SAVE:
            begin
                cmd.cordic_save = 1'b1;
                state_next = S_MUL_DV;
            end
            S_MUL_DV:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MS_DV;
                state_next = S_DV_SAVE;
            end
            S_DV_SAVE:
            begin
                cmd.dv_save = 1'b1;
                state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MS_X;
                state_next = S_ADD_X;
            end
            S_ADD_X:
            begin
                cmd.add_x = 1'b1;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MS_Y;
                state_next = S_ADD_Y;
            end
            S_ADD_Y:
            begin
                cmd.add_y = 1'b1;
                state_next = S_C2_INIT;
            end
            S_C2_INIT:
            begin
                cmd.cordic_init = 1'b1;
                cmd.cordic_half = 1'b1;
                cnt_next = '0;
                state_next = S_C2_RUN;
            end
            S_C2_RUN:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_C2_SAVE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_C2_SAVE:
            begin
                cmd.cordic_save = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* sv/uoi_datapath.sv */
`default_nettype none

module uoi_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  uoi_pkg::uoi_cmd_t cmd,
    output uoi_pkg::uoi_sts_t sts,
    input  wire logic [uoi_pkg::STEP_W-1:0] time_step,
    input  wire logic signed [uoi_pkg::VEL_W-1:0] lin_vel_in,
    input  wire logic signed [uoi_pkg::VEL_W-1:0] ang_vel_in,
    input  wire logic signed [uoi_pkg::POS_W-1:0] pose_x_in,
    input  wire logic signed [uoi_pkg::POS_W-1:0] pose_y_in,
    input  wire logic signed [uoi_pkg::HEAD_W-1:0] heading_in,
    output logic out_valid,
    input  wire logic out_stall,
    output logic signed [uoi_pkg::POS_W-1:0] pos_x,
    output logic signed [uoi_pkg::POS_W-1:0] pos_y,
    output logic signed [uoi_pkg::HEAD_W-1:0] heading,
    output logic signed [uoi_pkg::HALF_W-1:0] half_sin,
    output logic signed [uoi_pkg::HALF_W-1:0] half_cos,
    output logic signed [uoi_pkg::VEL_W-1:0] lin_vel,
    output logic signed [uoi_pkg::VEL_W-1:0] ang_vel
);
    import uoi_pkg::*;

    localparam logic signed [WRAP_W-1:0] TW = WRAP_W'(TWO_PI_Q);
    localparam logic signed [WRAP_W-1:0] PIW = WRAP_W'(PI_Q);
    localparam logic signed [ANG_W-1:0] PI_A = ANG_W'(PI_Q30);
    localparam logic signed [ANG_W-1:0] HPI_A = ANG_W'(HALF_PI_Q30);
    localparam logic signed [ANG_W-1:0] GAIN_A = ANG_W'(GAIN_Q30);
    localparam int SH_FULL = 30 - FRAC_BITS;
    localparam int SH_HALF = 29 - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(64'd1 << (STEP_W - 1));
    localparam logic signed [PROD_W-1:0] HALF30 = PROD_W'(64'd1 << 29);
    localparam logic signed [MUL_A_W-1:0] HALFQ = MUL_A_W'(64'd1 << (SH_FULL - 1));
    localparam logic signed [HALF_W-1:0] ONE_Q = HALF_W'(64'd1 << FRAC_BITS);
    localparam logic signed [POS_W+1:0] POS_MAX = (POS_W+2)'(64'h7fffffff);
    localparam logic signed [POS_W+1:0] POS_MIN = -(POS_W+2)'(64'h80000000);

    // state and work registers
    logic signed [POS_W-1:0] x_reg, y_reg;
    logic signed [HEAD_W-1:0] head_reg;
    logic signed [VEL_W-1:0] lv_reg, av_reg;
    logic signed [WRAP_W-1:0] wrap_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VEL_W-1:0] dv_reg;
    logic signed [ANG_W-1:0] cx_reg, cy_reg, ca_reg;
    logic neg_reg;
    logic signed [MUL_A_W-1:0] c_reg, s_reg;
    logic out_valid_reg;
    logic signed [POS_W-1:0] ox_reg, oy_reg;
    logic signed [HEAD_W-1:0] oh_reg;
    logic signed [HALF_W-1:0] ohs_reg, ohc_reg;
    logic signed [VEL_W-1:0] olv_reg, oav_reg;

    // multiplier operand select
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [VEL_W-1:0] mul_b;
    always_comb
    begin
        case (cmd.mul_sel)
            MS_HEAD:
            begin
                mul_a = $signed({16'd0, time_step});
                mul_b = av_reg;
            end
            MS_DV:
            begin
                mul_a = $signed({16'd0, time_step});
                mul_b = lv_reg;
            end
            MS_X:
            begin
                mul_a = c_reg;
                mul_b = dv_reg;
            end
            default:
            begin
                mul_a = s_reg;
                mul_b = dv_reg;
            end
        endcase
    end

    // rounding of the product
    logic signed [PROD_W-1:0] prod_r16, prod_r30;
    assign prod_r16 = (prod_reg + HALF16) >>> STEP_W;
    assign prod_r30 = (prod_reg + HALF30) >>> 30;

    // heading wrap steps
    logic signed [WRAP_W-1:0] tw_k;
    assign tw_k = TW <<< cmd.idx[2:0];

    // position add with saturation
    logic signed [POS_W+1:0] pos_sum;
    logic signed [POS_W-1:0] pos_sat;
    always_comb
    begin
        pos_sum = (cmd.add_x ? (POS_W+2)'(x_reg) : (POS_W+2)'(y_reg))
            + (POS_W+2)'($signed(prod_r30[25:0]));
        if (pos_sum > POS_MAX)
            pos_sat = POS_W'(POS_MAX);
        else if (pos_sum < POS_MIN)
            pos_sat = POS_W'(POS_MIN);
        else
            pos_sat = pos_sum[POS_W-1:0];
    end

    // cordic start angle and fold
    logic signed [ANG_W-1:0] ang0;
    assign ang0 = cmd.cordic_half ? (ANG_W'(head_reg) <<< SH_HALF)
                                  : (ANG_W'(head_reg) <<< SH_FULL);

    // cordic micro-rotation
    logic signed [ANG_W-1:0] sx, sy, at;
    assign sx = cx_reg >>> cmd.idx;
    assign sy = cy_reg >>> cmd.idx;
    assign at = atan_q30(cmd.idx);

    // half-angle outputs rounded and clamped
    logic signed [MUL_A_W-1:0] hs_r, hc_r;
    logic signed [HALF_W-1:0] hs_q, hc_q;
    assign hs_r = (s_reg + HALFQ) >>> SH_FULL;
    assign hc_r = (c_reg + HALFQ) >>> SH_FULL;
    always_comb
    begin
        if (hs_r > MUL_A_W'(ONE_Q))
            hs_q = ONE_Q;
        else if (hs_r < -MUL_A_W'(ONE_Q))
            hs_q = -ONE_Q;
        else
            hs_q = hs_r[HALF_W-1:0];
        if (hc_r > MUL_A_W'(ONE_Q))
            hc_q = ONE_Q;
        else if (hc_r < -MUL_A_W'(ONE_Q))
            hc_q = -ONE_Q;
        else
            hc_q = hc_r[HALF_W-1:0];
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            head_reg <= '0;
            lv_reg <= '0;
            av_reg <= '0;
        end
        else
        begin
            if (cmd.ld_vel)
            begin
                lv_reg <= lin_vel_in;
                av_reg <= ang_vel_in;
            end
            if (cmd.ld_pose)
            begin
                x_reg <= pose_x_in;
                y_reg <= pose_y_in;
                lv_reg <= '0;
                av_reg <= '0;
            end
            if (cmd.wrap_fix)
                head_reg <= (wrap_reg > PIW) ? HEAD_W'(wrap_reg - TW) : HEAD_W'(wrap_reg);
            if (cmd.add_x)
                x_reg <= pos_sat;
            if (cmd.add_y)
                y_reg <= pos_sat;
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.ld_pose)
            wrap_reg <= WRAP_W'(heading_in);
        else if (cmd.add_h)
            wrap_reg <= WRAP_W'(head_reg) + WRAP_W'($signed(prod_r16[VEL_W-1:0]));
        else if (cmd.wrap_pre)
        begin
            if (wrap_reg < 0)
                wrap_reg <= wrap_reg + (TW <<< WRAP_TOP);
        end
        else if (cmd.wrap_step)
        begin
            if (wrap_reg >= tw_k)
                wrap_reg <= wrap_reg - tw_k;
        end
        if (cmd.dv_save)
            dv_reg <= prod_r16[VEL_W-1:0];
        if (cmd.cordic_init)
        begin
            cx_reg <= GAIN_A;
            cy_reg <= '0;
            if (ang0 > HPI_A)
            begin
                ca_reg <= ang0 - PI_A;
                neg_reg <= 1'b1;
            end
            else if (ang0 < -HPI_A)
            begin
                ca_reg <= ang0 + PI_A;
                neg_reg <= 1'b1;
            end
            else
            begin
                ca_reg <= ang0;
                neg_reg <= 1'b0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (ca_reg >= 0)
            begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                ca_reg <= ca_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                ca_reg <= ca_reg + at;
            end
        end
        if (cmd.cordic_save)
        begin
            c_reg <= neg_reg ? MUL_A_W'(-cx_reg) : MUL_A_W'(cx_reg);
            s_reg <= neg_reg ? MUL_A_W'(-cy_reg) : MUL_A_W'(cy_reg);
        end
        if (cmd.out_load)
        begin
            ox_reg <= x_reg;
            oy_reg <= y_reg;
            oh_reg <= head_reg;
            ohs_reg <= hs_q;
            ohc_reg <= hc_q;
            olv_reg <= lv_reg;
            oav_reg <= av_reg;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign sts.out_full = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign pos_x = ox_reg;
    assign pos_y = oy_reg;
    assign heading = oh_reg;
    assign half_sin = ohs_reg;
    assign half_cos = ohc_reg;
    assign lin_vel = olv_reg;
    assign ang_vel = oav_reg;

endmodule

`default_nettype wire

/* sv/unicycle_odometry_integrator_core.sv */
// Unicycle dead-reckoning odometry integrator.
// Input channel (in_valid/in_stall) takes one command per transfer: tick,
// set velocity or set pose. Only a tick produces a transfer on the output
// channel (out_valid/out_stall) carrying pose, half-angle sin/cos and rates.
// Set velocity does not hold the input; set pose holds it for the heading wrap.
// A tick holds the input until its result is loaded into the output register:
// the heading wrap runs six compare-subtract steps, then two rotation CORDICs
// of CORDIC_STEPS iterations each share one micro-rotation unit, and the
// rate products go through one shared 32x24 multiplier.
// in_stall is high while a command is being worked on. The result sits in
// an output register; a new command is taken while it waits, and only the
// final load of the next result waits for the receiver to release stall.
// The time step register lives at APB byte address 0, reset value 655.
// Reset clears pose, rates and the output valid; it takes effect at once.
`default_nettype none

module unicycle_odometry_integrator_core #(
    parameter int CORDIC_STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [uoi_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [uoi_pkg::CMD_W-1:0] command,
    input  wire logic signed [uoi_pkg::VEL_W-1:0] lin_vel_in,
    input  wire logic signed [uoi_pkg::VEL_W-1:0] ang_vel_in,
    input  wire logic signed [uoi_pkg::POS_W-1:0] pose_x_in,
    input  wire logic signed [uoi_pkg::POS_W-1:0] pose_y_in,
    input  wire logic signed [uoi_pkg::HEAD_W-1:0] heading_in,
    output logic out_valid,
    input  wire logic out_stall,
    output logic signed [uoi_pkg::POS_W-1:0] pos_x,
    output logic signed [uoi_pkg::POS_W-1:0] pos_y,
    output logic signed [uoi_pkg::HEAD_W-1:0] heading,
    output logic signed [uoi_pkg::HALF_W-1:0] half_sin,
    output logic signed [uoi_pkg::HALF_W-1:0] half_cos,
    output logic signed [uoi_pkg::VEL_W-1:0] lin_vel,
    output logic signed [uoi_pkg::VEL_W-1:0] ang_vel
);
    import uoi_pkg::*;

    logic [STEP_W-1:0] time_step_reg;
    uoi_cmd_t cmd;
    uoi_sts_t sts;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= TIME_STEP_RST;
        else if (psel && penable && pwrite && pready && paddr == ADDR_TIME_STEP)
            time_step_reg <= pwdata[STEP_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TIME_STEP) ? {16'd0, time_step_reg} : 32'd0;

    uoi_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .command(command),
        .in_stall(in_stall),
        .sts(sts),
        .cmd(cmd)
    );

    uoi_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sts(sts),
        .time_step(time_step_reg),
        .lin_vel_in(lin_vel_in),
        .ang_vel_in(ang_vel_in),
        .pose_x_in(pose_x_in),
        .pose_y_in(pose_y_in),
        .heading_in(heading_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .heading(heading),
        .half_sin(half_sin),
        .half_cos(half_cos),
        .lin_vel(lin_vel),
        .ang_vel(ang_vel)
    );

endmodule

`default_nettype wire

/* sv/uoi_checker.sv */
`default_nettype none

module uoi_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic [uoi_pkg::CMD_W-1:0] command,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic [uoi_pkg::POS_W-1:0] pos_x,
    input wire logic signed [uoi_pkg::HALF_W-1:0] half_sin
);
    import uoi_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pos_x))
        else $error("output changed while stalled");

    // velocity update finishes in the accept cycle
    a_vel_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_SET_VEL |=> !in_stall)
        else $error("set velocity held the input");

    // a tick keeps the input busy
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_TICK |=> in_stall)
        else $error("tick did not occupy the block");

    // a new result only follows tick work
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

    // quaternion term stays within unit range
    a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (half_sin <= 18'sd65536) && (half_sin >= -18'sd65536))
        else $error("half_sin out of range");

endmodule

bind unicycle_odometry_integrator_core uoi_checker u_uoi_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x(pos_x),
    .half_sin(half_sin)
);

`default_nettype wire
